FILE: rtl/int32_to_decimal_ascii_top_defines.svh
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_top_defines.svh
// Assertion macros for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INT32_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked on i_clk, held off while reset is asserted
`define I2DA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on i_clk at every edge, reset included
`define I2DA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define I2DA_ASSERT(lbl, prop, msg)
`define I2DA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/i2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_pkg
// Types and constants shared by the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_DIGITS = 10;   // 2^32-1 has ten decimal digits
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = $clog2(WORD_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    typedef enum logic {
        CMD_UNSIGNED = 1'b0,
        CMD_SIGNED   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic [3:0] text_length;
        logic       last;
    } t_out_item;

    // control shared by every digit cell
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

endpackage

FILE: rtl/i2da_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_cell
// One BCD digit of the shift-and-add-3 chain.
// ----------------------------------------------------------------------------
module i2da_cell (
    input  logic                              i_clk,
    input  i2da_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_bit,
    output logic                              o_bit,
    output logic [i2da_pkg::DIGIT_W-1:0]      o_digit
);
    import i2da_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign w_adj = (r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;
    assign o_bit   = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[DIGIT_W-2:0], i_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: rtl/int32_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_top
// 32-bit binary word to decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a command (unsigned or two's
// complement signed) and a 32-bit word. Output channel: o_out_valid /
// i_out_stall carry one character per transfer, most significant first,
// with the total text length and a last flag on the final character.
// A negative signed word gives '-' then its magnitude digits; no leading
// zeros; zero gives "0".
// Operation: one word is handled at a time. After the input transfer a row of
// ten BCD digit cells runs 32 shift-and-add-3 steps, a length scan state
// follows, then one character per cycle leaves through the output register
// while the output is not stalled. The input is taken again as soon as the
// last character sits in the output register, even if it still waits there.
// Output stall freezes the output register and the emit counter.
// Reset returns the controller to idle and drops o_out_valid.
// ----------------------------------------------------------------------------
`include "int32_to_decimal_ascii_top_defines.svh"

module int32_to_decimal_ascii_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2da_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2da_pkg::t_out_item   o_out_data
);
    import i2da_pkg::*;

    // controller state
    t_state             r_state,    n_state;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;
    logic [WORD_W-1:0]  r_bin,      n_bin;      // magnitude, shifted out MSB first
    logic               r_neg,      n_neg;
    logic               r_sign_pend, n_sign_pend;
    logic [IDX_W-1:0]   r_idx,      n_idx;      // digit being emitted
    logic [3:0]         r_len,      n_len;

    // output register
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out,      n_out;

    t_cell_ctrl         w_ctrl;
    logic               w_in_fire;
    logic               w_load_out;
    logic               w_neg_in;
    logic [IDX_W-1:0]   w_top;

    logic [DIGIT_W-1:0] w_digits [NUM_DIGITS];
    logic [NUM_DIGITS:0] w_carry;

    // ---------------------------------------------------------------
    // Digit chain: cell 0 takes the next binary bit, each cell hands
    // its overflow bit to the next more significant cell.
    // ---------------------------------------------------------------
    assign w_carry[0] = r_bin[WORD_W-1];

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        i2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bit   (w_carry[g]),
            .o_bit   (w_carry[g+1]),
            .o_digit (w_digits[g])
        );
    end

    // most significant nonzero digit; zero keeps one digit
    always_comb begin
        w_top = '0;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (w_digits[k] != '0) begin
                w_top = IDX_W'(k);
            end
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_neg_in   = (i_in_data.command == CMD_SIGNED) && i_in_data.value[WORD_W-1];

    // while emitting, the output register refills whenever it is empty or its transfer completes
    assign w_load_out = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------
    // Next state and outputs
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bin       = r_bin;
        n_neg       = r_neg;
        n_sign_pend = r_sign_pend;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_ctrl      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    w_ctrl.clear = 1'b1;
                    n_neg        = w_neg_in;
                    n_bin        = w_neg_in ? (WORD_W'(0) - i_in_data.value)
                                            : i_in_data.value;
                    n_cnt        = '0;
                    n_state      = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctrl.shift = 1'b1;
                n_bin        = {r_bin[WORD_W-2:0], 1'b0};
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_idx       = w_top;
                n_len       = 4'(w_top) + 4'd1 + 4'(r_neg);
                n_sign_pend = r_neg;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load_out) begin
                    n_out_valid       = 1'b1;
                    n_out.text_length = r_len;
                    if (r_sign_pend) begin
                        n_out.character = CHAR_MINUS;
                        n_out.last      = 1'b0;
                        n_sign_pend     = 1'b0;
                    end else begin
                        n_out.character = CHAR_ZERO + 8'(w_digits[r_idx]);
                        n_out.last      = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx - IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign_pend <= n_sign_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_neg <= n_neg;
        r_idx <= n_idx;
        r_len <= n_len;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `I2DA_ASSERT(a_last_is_digit, (r_out_valid && r_out.last) |-> (r_out.character >= CHAR_ZERO && r_out.character <= CHAR_NINE), "last character is not a digit")
    `I2DA_ASSERT(a_minus_not_last, (r_out_valid && r_out.character == CHAR_MINUS) |-> !r_out.last, "minus sign flagged as last")
    `I2DA_ASSERT(a_len_range, r_out_valid |-> (r_out.text_length >= 4'd1 && r_out.text_length <= 4'd11), "text length out of range")
    `I2DA_ASSERT(a_fire_starts_conv, w_in_fire |=> (r_state == ST_CONV && r_cnt == '0), "input transfer did not start conversion")

endmodule

FILE: dv/tb_int32_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int32_to_decimal_ascii_top
// Self-checking bench for the 32-bit binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Words go in with an unsigned or signed command. A local text predictor
// works out the characters each accepted word should produce and queues
// them. A checker compares every output transfer with the oldest queued
// character, field by field. The stimulus has three parts:
//   - a directed set of boundary words,
//   - random words under three idling mixes,
//   - a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------

module tb_int32_to_decimal_ascii_top;

    import i2da_pkg::*;

    localparam int CLK_PERIOD_NS   = 20;
    localparam int RESET_CYCLES    = 4;
    localparam int RADIX           = 10;
    localparam int TAIL_CYCLES     = 60;       // longer than one conversion and its longest text
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TIMEOUT_NS      = 20_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // characters still owed by the block, oldest first
    t_out_item expected_chars[$];
    int        char_errors     = 0;

    // idle odds in percent for each side; hold-off counted by the
    // output stall process
    int        in_idle_pct     = 0;
    int        out_idle_pct    = 0;
    int        out_hold_cycles = 0;

    int32_to_decimal_ascii_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Text predictor: queues the characters of one converted word.
    // A negative signed word is negated in 32-bit unsigned arithmetic, so
    // the most negative word yields magnitude 2147483648.
    // ------------------------------------------------------------------------
    function automatic void predict_text(input t_cmd cmd, input logic [31:0] word);
        logic       negative;
        logic [31:0] magnitude;
        logic [7:0] digits[$];
        logic [3:0] text_len;
        negative  = (cmd == CMD_SIGNED) && word[31];
        magnitude = negative ? (32'd0 - word) : word;
        do begin
            digits.push_front(CHAR_ZERO + 8'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        text_len = 4'(digits.size() + (negative ? 1 : 0));
        if (negative) begin
            expected_chars.push_back('{character: CHAR_MINUS, text_length: text_len,
                                       last: 1'b0});
        end
        foreach (digits[i]) begin
            expected_chars.push_back('{character: digits[i], text_length: text_len,
                                       last: (i == digits.size() - 1)});
        end
    endfunction

    // Random word with a spread of text lengths: shifted words for short
    // numbers, small negatives, words next to powers of ten, full range.
    function automatic logic [31:0] random_word();
        logic [31:0] pow10;
        pow10 = 32'd1;
        case ($urandom_range(0, 3))
            0: return 32'($urandom()) >> $urandom_range(0, 31);
            1: return 32'd0 - (32'($urandom()) >> $urandom_range(4, 31));
            2: begin
                repeat ($urandom_range(0, 9)) pow10 = pow10 * RADIX;
                pow10 = pow10 + 32'($urandom_range(0, 2)) - 32'd1;
                return $urandom_range(0, 1) ? (32'd0 - pow10) : pow10;
            end
            default: return 32'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Entered just after a rising edge; valid is only changed at
    // falling edges, once per edge. Prediction happens on the accepted edge.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_cmd cmd, input logic [31:0] word);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= '{command: cmd, value: word};
        do @(posedge i_clk); while (o_in_stall);
        predict_text(cmd, word);
    endtask

    // Sender pause: drop valid and wait until every owed character is out.
    task automatic wait_for_text_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output stall: random per cycle, or forced high during a hold-off.
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                out_hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: one compare per output transfer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_chars
        t_out_item owed;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got '%c' len %0d last %0b",
                         $time, o_out_data.character, o_out_data.text_length,
                         o_out_data.last);
                char_errors++;
            end else begin
                owed = expected_chars.pop_front();
                if (o_out_data.character !== owed.character) begin
                    $display("%0t: character mismatch: expected %0d, got %0d",
                             $time, owed.character, o_out_data.character);
                    char_errors++;
                end
                if (o_out_data.text_length !== owed.text_length) begin
                    $display("%0t: text_length mismatch: expected %0d, got %0d",
                             $time, owed.text_length, o_out_data.text_length);
                    char_errors++;
                end
                if (o_out_data.last !== owed.last) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, owed.last, o_out_data.last);
                    char_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Boundary words: zero, single digits, powers of ten, full-scale words
    // both ways, the most negative signed word, alternating bit patterns.
    task automatic test_directed_values();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_word(CMD_UNSIGNED, 32'd0);
        send_word(CMD_SIGNED,   32'd0);
        send_word(CMD_UNSIGNED, 32'd1);
        send_word(CMD_SIGNED,   32'd1);
        send_word(CMD_UNSIGNED, 32'd9);
        send_word(CMD_UNSIGNED, 32'd10);
        send_word(CMD_SIGNED,   32'd99);
        send_word(CMD_UNSIGNED, 32'd100);
        send_word(CMD_UNSIGNED, 32'd999_999_999);
        send_word(CMD_UNSIGNED, 32'd1_000_000_000);
        send_word(CMD_UNSIGNED, 32'hFFFF_FFFF);
        send_word(CMD_SIGNED,   32'hFFFF_FFFF);
        send_word(CMD_SIGNED,   32'h8000_0000);
        send_word(CMD_UNSIGNED, 32'h8000_0000);
        send_word(CMD_SIGNED,   32'h7FFF_FFFF);
        send_word(CMD_UNSIGNED, 32'h7FFF_FFFF);
        send_word(CMD_SIGNED,   32'hFFFF_FFF6);    // -10
        send_word(CMD_SIGNED,   32'hC465_3600);    // -1000000000
        send_word(CMD_SIGNED,   32'hC465_3601);    // -999999999
        send_word(CMD_UNSIGNED, 32'hAAAA_AAAA);
        send_word(CMD_SIGNED,   32'h5555_5555);
        send_word(CMD_SIGNED,   32'hAAAA_AAAA);
        wait_for_text_drain();
    endtask

    task automatic test_random_words(input int count, input int src_pct, input int dst_pct);
        in_idle_pct  = src_pct;
        out_idle_pct = dst_pct;
        repeat (count) send_word(t_cmd'($urandom_range(0, 1)), random_word());
    endtask

    // Output held off for a long stretch while words keep coming, so the
    // output register fills and the input stalls.
    task automatic test_output_backpressure();
        in_idle_pct     = 0;
        out_idle_pct    = 0;
        out_hold_cycles = HOLD_OFF_CYCLES;
        repeat (20) send_word(t_cmd'($urandom_range(0, 1)), random_word());
        wait_for_text_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_values();
        test_random_words(150, 21, 62);
        wait_for_text_drain();
        test_random_words(150, 62, 21);
        test_output_backpressure();
        test_random_words(140, 0, 0);
        wait_for_text_drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (char_errors == 0 && expected_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d characters still owed", $time, expected_chars.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
